// ----- design/udpe_pkg.sv -----
// udpe_pkg: request and status codes, beat payload types, character mask helper
// no dependencies; imported by user_phrase_dictionary_engine_core

package udpe_pkg;

    localparam int LEN_W   = 4;
    localparam int FREQ_W  = 32;
    localparam int STAMP_W = 11;
    localparam int CHARS_W = 128;
    localparam int TOTAL_W = 11;
    localparam int IDX_W   = 10;
    localparam logic [TOTAL_W-1:0] CAP_RESET = 11'd1024;

    typedef enum logic [2:0] {
        REQ_ADD   = 3'd0,
        REQ_FIND  = 3'd1,
        REQ_INCR  = 3'd2,
        REQ_DEL   = 3'd3,
        REQ_FIRST = 3'd4,
        REQ_NEXT  = 3'd5
    } req_t;

    typedef enum logic [2:0] {
        STS_INSERTED    = 3'd0,
        STS_INCREMENTED = 3'd1,
        STS_REPLACED    = 3'd2,
        STS_FOUND       = 3'd3,
        STS_NONE        = 3'd4,
        STS_DROPPED     = 3'd5,
        STS_DELETED     = 3'd6,
        STS_WAS_DELETED = 3'd7
    } status_t;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [8:0]        group_id;
        logic [LEN_W-1:0]  phrase_len;
        logic [63:0]       phrase_low;
        logic [63:0]       phrase_high;
        logic [FREQ_W-1:0] add_freq;
        logic [IDX_W-1:0]  entry_index;
    } udpe_in_t;

    typedef struct packed {
        status_t            status;
        logic [IDX_W-1:0]   result_index;
        logic [LEN_W-1:0]   result_len;
        logic [FREQ_W-1:0]  result_freq;
        logic [TOTAL_W-1:0] phrase_total;
        logic [FREQ_W-1:0]  freq_total;
    } udpe_out_t;

    function automatic logic [CHARS_W-1:0] chars_mask(input logic [LEN_W-1:0] len);
        logic [CHARS_W-1:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < len) begin
                m[i*16 +: 16] = 16'hFFFF;
            end
        end
        return m;
    endfunction

endpackage

// ----- design/udpe_entry_ram.sv -----
// udpe_entry_ram: entry record and chain link storage, one shared read port
// registered read data; depends on nothing but its parameters

module udpe_entry_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 176,
    parameter int LINK_W = 11
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    output logic [LINK_W-1:0] rd_link,
    input  logic              dat_we,
    input  logic [ADDR_W-1:0] dat_addr,
    input  logic [DATA_W-1:0] dat_wdata,
    input  logic              lnk_we,
    input  logic [ADDR_W-1:0] lnk_addr,
    input  logic [LINK_W-1:0] lnk_wdata
);

    logic [DATA_W-1:0] dat_mem [DEPTH];
    logic [LINK_W-1:0] lnk_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (dat_we) begin
            dat_mem[dat_addr] <= dat_wdata;
        end
        if (lnk_we) begin
            lnk_mem[lnk_addr] <= lnk_wdata;
        end
        if (rd_en) begin
            rd_data <= dat_mem[rd_addr];
            rd_link <= lnk_mem[rd_addr];
        end
    end

endmodule

// ----- design/udpe_group_ram.sv -----
// udpe_group_ram: per-group head, tail and valid flag storage
// registered read data; depends on nothing but its parameters

module udpe_group_ram #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9,
    parameter int DATA_W = 21
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              we,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- design/user_phrase_dictionary_engine_core.sv -----
// user_phrase_dictionary_engine_core: sequencer that walks group chains in memory
// depends on udpe_pkg, udpe_entry_ram and udpe_group_ram
// add/find/first/next walk a group chain at one entry per cycle, set by the single
// entry memory read port; increment/delete read the entry named by its index, and
// an add that appends to a nonempty group also links the old tail; one request at a time
// reset: synchronous active-low; afterwards a clearing pass over all GROUP_COUNT groups
// marks every group empty before the first request is taken

module user_phrase_dictionary_engine_core
    import udpe_pkg::*;
#(
    parameter int ENTRY_COUNT = 1024,
    parameter int GROUP_COUNT = 512,
    parameter int MAX_CHARS   = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  udpe_in_t      s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output udpe_out_t     m_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [10:0]   cfg_data
);

    localparam int EW  = $clog2(ENTRY_COUNT);
    localparam int CW  = $clog2(ENTRY_COUNT + 1);
    localparam int GW  = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int CHW = 16 * MAX_CHARS;

    typedef struct packed {
        logic               deleted;
        logic [STAMP_W-1:0] stamp;
        logic [LEN_W-1:0]   len;
        logic [FREQ_W-1:0]  freq;
        logic [CHW-1:0]     chars;
    } entry_t;

    typedef struct packed {
        logic          valid;
        logic [EW-1:0] link;
    } link_t;

    typedef struct packed {
        logic          valid;
        logic [EW-1:0] head;
        logic [EW-1:0] tail;
    } group_t;

    typedef struct packed {
        status_t           status;
        logic [IDX_W-1:0]  index;
        logic [LEN_W-1:0]  len;
        logic [FREQ_W-1:0] freq;
    } res_t;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_GRP   = 7'b0000100,
        ST_WALK  = 7'b0001000,
        ST_ENTRY = 7'b0010000,
        ST_LINK  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    udpe_in_t          req_reg, req_next;
    logic [GW-1:0]     gidx_reg, gidx_next;
    logic [EW-1:0]     cur_reg, cur_next;
    logic              first_reg, first_next;
    logic [EW-1:0]     vic_reg, vic_next;
    logic [FREQ_W-1:0] vfreq_reg, vfreq_next;
    logic [STAMP_W-1:0] vstamp_reg, vstamp_next;
    logic              hdel_reg, hdel_next;
    logic [CW-1:0]     alloc_reg, alloc_next;
    logic [FREQ_W-1:0] fsum_reg, fsum_next;
    logic [10:0]       cap_reg;
    logic [GW-1:0]     clr_reg, clr_next;
    res_t              res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    udpe_out_t         out_reg, out_next;

    logic              e_rd_en, e_we, l_we, g_rd_en, g_we;
    logic [EW-1:0]     e_rd_addr, e_wr_addr, l_wr_addr;
    entry_t            e_q, e_wdata;
    link_t             l_q, l_wdata;
    logic [GW-1:0]     g_rd_addr, g_wr_addr;
    group_t            g_q, g_wdata;

    udpe_entry_ram #(
        .DEPTH (ENTRY_COUNT),
        .ADDR_W(EW),
        .DATA_W($bits(entry_t)),
        .LINK_W($bits(link_t))
    ) u_entry (
        .aclk     (aclk),
        .rd_en    (e_rd_en),
        .rd_addr  (e_rd_addr),
        .rd_data  (e_q),
        .rd_link  (l_q),
        .dat_we   (e_we),
        .dat_addr (e_wr_addr),
        .dat_wdata(e_wdata),
        .lnk_we   (l_we),
        .lnk_addr (l_wr_addr),
        .lnk_wdata(l_wdata)
    );

    udpe_group_ram #(
        .DEPTH (GROUP_COUNT),
        .ADDR_W(GW),
        .DATA_W($bits(group_t))
    ) u_group (
        .aclk   (aclk),
        .rd_en  (g_rd_en),
        .rd_addr(g_rd_addr),
        .rd_data(g_q),
        .we     (g_we),
        .wr_addr(g_wr_addr),
        .wr_data(g_wdata)
    );

    logic [31:0]        grem;
    logic [CHW-1:0]     req_mask, req_chars;
    logic               len_ok, live, match, better, room, s_idx_ok;
    logic [31:0]        cap_eff;
    entry_t             new_entry;
    res_t               res_none;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    always_comb begin
        grem = 32'(s_data.group_id);
        for (int k = 8; k >= 0; k--) begin
            if (grem >= (32'(GROUP_COUNT) << k)) begin
                grem = grem - (32'(GROUP_COUNT) << k);
            end
        end
    end

    assign req_mask  = CHW'(chars_mask(req_reg.phrase_len));
    assign req_chars = CHW'({req_reg.phrase_high, req_reg.phrase_low}) & req_mask;
    assign len_ok    = (req_reg.phrase_len != '0) && (32'(req_reg.phrase_len) <= 32'(MAX_CHARS));
    assign cap_eff   = (32'(cap_reg) < 32'(ENTRY_COUNT)) ? 32'(cap_reg) : 32'(ENTRY_COUNT);
    assign room      = 32'(alloc_reg) < cap_eff;
    assign s_idx_ok  = 32'(s_data.entry_index) < 32'(alloc_reg);
    assign live      = !e_q.deleted;
    assign match     = live && (e_q.len == req_reg.phrase_len)
                       && (((e_q.chars ^ req_chars) & req_mask) == '0);
    assign better    = (e_q.freq < vfreq_reg)
                       || ((e_q.freq == vfreq_reg) && (vstamp_reg > e_q.stamp));
    assign res_none  = '{status: STS_NONE, index: '0, len: '0, freq: '0};

    always_comb begin
        new_entry.deleted = 1'b0;
        new_entry.stamp   = STAMP_W'(alloc_reg);
        new_entry.len     = req_reg.phrase_len;
        new_entry.freq    = req_reg.add_freq;
        new_entry.chars   = req_chars;
    end

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        gidx_next    = gidx_reg;
        cur_next     = cur_reg;
        first_next   = first_reg;
        vic_next     = vic_reg;
        vfreq_next   = vfreq_reg;
        vstamp_next  = vstamp_reg;
        hdel_next    = hdel_reg;
        alloc_next   = alloc_reg;
        fsum_next    = fsum_reg;
        clr_next     = clr_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        e_rd_en      = 1'b0;
        e_rd_addr    = cur_reg;
        e_we         = 1'b0;
        e_wr_addr    = cur_reg;
        e_wdata      = e_q;
        l_we         = 1'b0;
        l_wr_addr    = cur_reg;
        l_wdata      = '0;
        g_rd_en      = 1'b0;
        g_rd_addr    = gidx_reg;
        g_we         = 1'b0;
        g_wr_addr    = gidx_reg;
        g_wdata      = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                g_we      = 1'b1;
                g_wr_addr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (32'(clr_reg) == 32'(GROUP_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    req_next   = s_data;
                    gidx_next  = GW'(grem);
                    first_next = 1'b1;
                    res_next   = res_none;
                    state_next = ST_DONE;
                    unique case (s_data.req_type)
                        REQ_ADD, REQ_FIND, REQ_FIRST: begin
                            g_rd_en    = 1'b1;
                            g_rd_addr  = GW'(grem);
                            state_next = ST_GRP;
                        end
                        REQ_INCR, REQ_DEL: begin
                            if (s_idx_ok) begin
                                e_rd_en    = 1'b1;
                                e_rd_addr  = EW'(s_data.entry_index);
                                cur_next   = EW'(s_data.entry_index);
                                state_next = ST_ENTRY;
                            end
                        end
                        REQ_NEXT: begin
                            if (s_idx_ok) begin
                                e_rd_en    = 1'b1;
                                e_rd_addr  = EW'(s_data.entry_index);
                                cur_next   = EW'(s_data.entry_index);
                                state_next = ST_WALK;
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_GRP: begin
                state_next = ST_DONE;
                if ((req_reg.req_type != REQ_FIRST) && !len_ok) begin
                    if (req_reg.req_type == REQ_ADD) begin
                        res_next.status = STS_DROPPED;
                    end
                end else if (g_q.valid) begin
                    e_rd_en    = 1'b1;
                    e_rd_addr  = g_q.head;
                    cur_next   = g_q.head;
                    state_next = ST_WALK;
                end else if (req_reg.req_type == REQ_ADD) begin
                    if (room) begin
                        e_we       = 1'b1;
                        e_wr_addr  = EW'(alloc_reg);
                        e_wdata    = new_entry;
                        l_we       = 1'b1;
                        l_wr_addr  = EW'(alloc_reg);
                        g_we       = 1'b1;
                        g_wdata    = '{valid: 1'b1, head: EW'(alloc_reg), tail: EW'(alloc_reg)};
                        fsum_next  = fsum_reg + req_reg.add_freq;
                        alloc_next = alloc_reg + 1'b1;
                        res_next   = '{status: STS_INSERTED, index: IDX_W'(alloc_reg),
                                       len: req_reg.phrase_len, freq: req_reg.add_freq};
                    end else begin
                        res_next.status = STS_DROPPED;
                    end
                end
            end
            ST_WALK: begin
                first_next = 1'b0;
                if ((req_reg.req_type == REQ_ADD) || (req_reg.req_type == REQ_FIND)) begin
                    if (first_reg) begin
                        vic_next    = cur_reg;
                        vfreq_next  = e_q.freq;
                        vstamp_next = e_q.stamp;
                        hdel_next   = e_q.deleted;
                    end else if (!hdel_reg && live && better) begin
                        vic_next    = cur_reg;
                        vfreq_next  = e_q.freq;
                        vstamp_next = e_q.stamp;
                    end
                end
                if (((req_reg.req_type == REQ_ADD) || (req_reg.req_type == REQ_FIND)) && match) begin
                    state_next = ST_DONE;
                    if (req_reg.req_type == REQ_ADD) begin
                        e_we         = 1'b1;
                        e_wdata.freq = e_q.freq + 1'b1;
                        fsum_next    = fsum_reg + 1'b1;
                        res_next     = '{status: STS_INCREMENTED, index: IDX_W'(cur_reg),
                                         len: e_q.len, freq: e_q.freq + 1'b1};
                    end else begin
                        res_next = '{status: STS_FOUND, index: IDX_W'(cur_reg),
                                     len: e_q.len, freq: e_q.freq};
                    end
                end else if ((req_reg.req_type == REQ_FIRST && live)
                             || (req_reg.req_type == REQ_NEXT && live && !first_reg)) begin
                    state_next = ST_DONE;
                    res_next   = '{status: STS_FOUND, index: IDX_W'(cur_reg),
                                   len: e_q.len, freq: e_q.freq};
                end else if (l_q.valid) begin
                    e_rd_en   = 1'b1;
                    e_rd_addr = l_q.link;
                    cur_next  = l_q.link;
                end else begin
                    state_next = ST_DONE;
                    if (req_reg.req_type == REQ_ADD) begin
                        if (room) begin
                            e_we       = 1'b1;
                            e_wr_addr  = EW'(alloc_reg);
                            e_wdata    = new_entry;
                            l_we       = 1'b1;
                            l_wr_addr  = EW'(alloc_reg);
                            g_we       = 1'b1;
                            g_wdata    = '{valid: 1'b1, head: g_q.head, tail: EW'(alloc_reg)};
                            fsum_next  = fsum_reg + req_reg.add_freq;
                            alloc_next = alloc_reg + 1'b1;
                            res_next   = '{status: STS_INSERTED, index: IDX_W'(alloc_reg),
                                           len: req_reg.phrase_len, freq: req_reg.add_freq};
                            state_next = ST_LINK;
                        end else begin
                            e_we      = 1'b1;
                            e_wr_addr = vic_next;
                            e_wdata   = new_entry;
                            res_next  = '{status: STS_REPLACED, index: IDX_W'(vic_next),
                                          len: req_reg.phrase_len, freq: req_reg.add_freq};
                        end
                    end
                end
            end
            ST_ENTRY: begin
                state_next = ST_DONE;
                if (req_reg.req_type == REQ_INCR) begin
                    e_we         = 1'b1;
                    e_wdata.freq = e_q.freq + 1'b1;
                    fsum_next    = fsum_reg + 1'b1;
                    res_next     = '{status: STS_INCREMENTED, index: IDX_W'(cur_reg),
                                     len: e_q.len, freq: e_q.freq + 1'b1};
                end else if (e_q.deleted) begin
                    res_next = '{status: STS_WAS_DELETED, index: IDX_W'(cur_reg),
                                 len: e_q.len, freq: e_q.freq};
                end else begin
                    e_we            = 1'b1;
                    e_wdata.deleted = 1'b1;
                    res_next        = '{status: STS_DELETED, index: IDX_W'(cur_reg),
                                        len: e_q.len, freq: e_q.freq};
                end
            end
            ST_LINK: begin
                l_we       = 1'b1;
                l_wr_addr  = g_q.tail;
                l_wdata    = '{valid: 1'b1, link: EW'(res_reg.index)};
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    out_next.status       = res_reg.status;
                    out_next.result_index = res_reg.index;
                    out_next.result_len   = res_reg.len;
                    out_next.result_freq  = res_reg.freq;
                    out_next.phrase_total = TOTAL_W'(alloc_reg);
                    out_next.freq_total   = fsum_reg;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            alloc_reg   <= '0;
            fsum_reg    <= '0;
            cap_reg     <= CAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            alloc_reg   <= alloc_next;
            fsum_reg    <= fsum_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        gidx_reg   <= gidx_next;
        cur_reg    <= cur_next;
        first_reg  <= first_next;
        vic_reg    <= vic_next;
        vfreq_reg  <= vfreq_next;
        vstamp_reg <= vstamp_next;
        hdel_reg   <= hdel_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    a_no_entry_write_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !e_we)
        else $error("entry write during group clearing pass");

    a_alloc_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(alloc_reg) <= 32'(ENTRY_COUNT))
        else $error("allocation count beyond table size");

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(e_rd_en && e_we))
        else $error("entry read and write in the same cycle");

    a_beat_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result beat raised outside the done state");

endmodule
